[design/i2cmts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master transaction sequencer package
// Shared phase codes, action codes, stream widths and the item, result and
// sequencer state structures.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

    // Stream widths
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    // Request kinds carried in s_tuser
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_POLL  = 2'd2;

    // Sequencer phases
    localparam logic [3:0] PH_FREE    = 4'd0;
    localparam logic [3:0] PH_SB      = 4'd1;
    localparam logic [3:0] PH_ADDR    = 4'd2;
    localparam logic [3:0] PH_EXTRA   = 4'd3;
    localparam logic [3:0] PH_RESTART = 4'd4;
    localparam logic [3:0] PH_RESB    = 4'd5;
    localparam logic [3:0] PH_TX      = 4'd6;
    localparam logic [3:0] PH_RX      = 4'd7;
    localparam logic [3:0] PH_STOP    = 4'd8;
    localparam logic [3:0] PH_CLOSE   = 4'd9;
    localparam logic [3:0] PH_IDLE    = 4'd10;

    // One incoming request
    typedef struct packed {
        logic [1:0]  action;
        logic [6:0]  dev_addr;
        logic [1:0]  extra_count;
        logic [23:0] extra_bytes;
        logic [15:0] length;
        logic        flag_sb;
        logic        flag_addr;
        logic        flag_txe;
        logic        flag_btf;
        logic        flag_rxne;
        logic        bus_busy;
        logic [7:0]  data_byte;
    } item_t;

    // One result
    typedef struct packed {
        logic       start_error;
        logic       send_start;
        logic       ack_enable;
        logic       byte_out_valid;
        logic [7:0] byte_out;
        logic       data_taken;
        logic       clear_ack;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       send_stop;
        logic       done_res;
        logic       is_busy;
    } result_t;

    // Sequencer control state (byte count and extra bytes kept apart)
    typedef struct packed {
        logic [3:0] phase;
        logic       active;
        logic       write_dir;
        logic [6:0] target_addr;
        logic [1:0] extra_left;
    } seq_state_t;

endpackage
`default_nettype wire

[design/i2c_master_transaction_sequencer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master transaction sequencer core
// Drives the START/address/extra/data/STOP order of an I2C master from
// sampled bus status flags, one request in and one result out.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ channel carries a kind in s_tuser (start read,
//   start write, poll) and the operands plus the current bus status flags
//   in s_tdata. Every request yields exactly one result on the m_ channel
//   with the bus commands to issue (start, address/data byte, ack clear,
//   stop), a received byte, done and busy indications.
//   A start request while a transfer runs is refused with start_error.
// Timing:
//   A request is held in the input register and is then evaluated into
//   the output register, whose valid flag drives m_tvalid. One request
//   per cycle is sustained while m_tready stays high; the sequencer state
//   is updated in the same cycle that the result register is loaded.
// Reset and stall:
//   aresetn (synchronous, active low) returns the sequencer to idle and
//   empties both registers. While m_tready is low the held result stays put,
//   one more request is absorbed by the input register, then s_tready drops.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer_core
    import i2cmts_pkg::*;
#(
    parameter int LEN_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [6:0] dev_addr, [8:7] extra_count, [32:9] extra_bytes, [48:33] length,
    // [49] flag_sb, [50] flag_addr, [51] flag_txe, [52] flag_btf,
    // [53] flag_rxne, [54] bus_busy, [62:55] data_byte, [63] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] action
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [0] start_error, [1] send_start, [2] ack_enable, [3] byte_out_valid,
    // [11:4] byte_out, [12] data_taken, [13] clear_ack, [14] rx_valid,
    // [22:15] rx_byte, [23] send_stop, [24] done_res, [25] is_busy, [31:26] zero
    output logic [M_TDATA_W-1:0]      m_tdata
);

    logic                 in_valid_reg, in_valid_next;
    logic [S_TDATA_W-1:0] in_data_reg;
    logic [S_TUSER_W-1:0] in_user_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    seq_state_t           st_reg, st_next;
    logic [LEN_BITS-1:0]  bytes_left_reg, bytes_left_next;
    logic [23:0]          extra_word_reg, extra_word_next;
    logic                 s_fire;
    logic                 proc;
    item_t                item;
    result_t              res;

    // Handshake: evaluate when the result slot is free or draining
    assign proc     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Unpack the held request
    assign item.action      = in_user_reg;
    assign item.dev_addr    = in_data_reg[6:0];
    assign item.extra_count = in_data_reg[8:7];
    assign item.extra_bytes = in_data_reg[32:9];
    assign item.length      = in_data_reg[48:33];
    assign item.flag_sb     = in_data_reg[49];
    assign item.flag_addr   = in_data_reg[50];
    assign item.flag_txe    = in_data_reg[51];
    assign item.flag_btf    = in_data_reg[52];
    assign item.flag_rxne   = in_data_reg[53];
    assign item.bus_busy    = in_data_reg[54];
    assign item.data_byte   = in_data_reg[62:55];

    i2cmts_step #(
        .LEN_BITS (LEN_BITS)
    ) u_step (
        .item            (item),
        .st              (st_reg),
        .bytes_left      (bytes_left_reg),
        .extra_word      (extra_word_reg),
        .st_next         (st_next),
        .bytes_left_next (bytes_left_next),
        .extra_word_next (extra_word_next),
        .res             (res)
    );

    // Valid flags of both registers
    always_comb begin
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (proc) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (proc) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            st_reg         <= '{phase: PH_IDLE, active: 1'b0, write_dir: 1'b0,
                                target_addr: 7'd0, extra_left: 2'd0};
            bytes_left_reg <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (proc) begin
                st_reg         <= st_next;
                bytes_left_reg <= bytes_left_next;
            end
        end
    end

    // Payload: hold the request, load the result, keep the extra bytes
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
        if (proc) begin
            extra_word_reg <= extra_word_next;
            out_data_reg   <= {6'd0, res.is_busy, res.done_res, res.send_stop,
                               res.rx_byte, res.rx_valid, res.clear_ack,
                               res.data_taken, res.byte_out, res.byte_out_valid,
                               res.ack_enable, res.send_start, res.start_error};
        end
    end

endmodule
`default_nettype wire

[design/i2cmts_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master transaction sequencer step
// Evaluates one request against the sequencer state: start latching, then
// up to two chained phases with the same bus status flags.
// ----------------------------------------------------------------------------
module i2cmts_step
    import i2cmts_pkg::*;
#(
    parameter int LEN_BITS = 16
) (
    input  item_t               item,
    input  seq_state_t          st,
    input  logic [LEN_BITS-1:0] bytes_left,
    input  logic [23:0]         extra_word,
    output seq_state_t          st_next,
    output logic [LEN_BITS-1:0] bytes_left_next,
    output logic [23:0]         extra_word_next,
    output result_t             res
);

    always_comb begin
        logic                is_start;
        logic                again;
        logic                err;
        logic [1:0]          idx;
        logic [7:0]          xbyte;
        seq_state_t          s;
        logic [LEN_BITS-1:0] bl;
        logic [23:0]         xw;

        is_start = (item.action == ACT_READ) || (item.action == ACT_WRITE);
        s        = st;
        bl       = bytes_left;
        xw       = extra_word;
        err      = 1'b0;
        res      = '0;
        again    = 1'b0;
        idx      = 2'd0;
        xbyte    = 8'd0;

        // Latch a start request or refuse it while busy
        if (is_start) begin
            if (st.active) begin
                err = 1'b1;
            end else begin
                s.write_dir   = (item.action == ACT_WRITE);
                s.target_addr = item.dev_addr;
                s.extra_left  = item.extra_count;
                s.phase       = PH_FREE;
                s.active      = 1'b1;
                bl            = LEN_BITS'(item.length);
                xw            = item.extra_bytes;
            end
        end

        // Walk the phases; only an acknowledged address chains into a second one
        if (s.active && !err) begin
            again = 1'b1;
            for (int k = 0; k < 2; k++) begin
                if (again) begin
                    again = 1'b0;
                    unique case (s.phase)
                        PH_FREE: begin
                            if (!item.bus_busy) begin
                                res.send_start = 1'b1;
                                res.ack_enable = !s.write_dir;
                                s.phase        = PH_SB;
                            end
                        end
                        PH_SB: begin
                            if (item.flag_sb) begin
                                res.byte_out_valid = 1'b1;
                                res.byte_out = {s.target_addr,
                                                (s.extra_left == 2'd0) && !s.write_dir};
                                s.phase = PH_ADDR;
                            end
                        end
                        PH_ADDR: begin
                            if (item.flag_addr) begin
                                if (s.extra_left != 2'd0) begin
                                    s.phase = PH_EXTRA;
                                end else if (s.write_dir) begin
                                    s.phase = PH_TX;
                                end else begin
                                    s.phase = PH_RX;
                                end
                                again = 1'b1;
                            end
                        end
                        PH_EXTRA: begin
                            if (item.flag_txe) begin
                                // Most significant used byte goes out first
                                idx = s.extra_left - 2'd1;
                                unique case (idx)
                                    2'd0:    xbyte = xw[7:0];
                                    2'd1:    xbyte = xw[15:8];
                                    2'd2:    xbyte = xw[23:16];
                                    default: xbyte = 8'd0;
                                endcase
                                res.byte_out_valid = 1'b1;
                                res.byte_out       = xbyte;
                                s.extra_left       = s.extra_left - 2'd1;
                                if (s.extra_left == 2'd0) begin
                                    s.phase = s.write_dir ? PH_TX : PH_RESTART;
                                end
                            end
                        end
                        PH_RESTART: begin
                            if (item.flag_btf) begin
                                res.send_start = 1'b1;
                                res.ack_enable = 1'b1;
                                s.phase        = PH_RESB;
                            end
                        end
                        PH_RESB: begin
                            if (item.flag_sb) begin
                                res.byte_out_valid = 1'b1;
                                res.byte_out       = {s.target_addr, 1'b1};
                                s.phase            = PH_RX;
                            end
                        end
                        PH_TX: begin
                            if (bl == '0) begin
                                s.phase = PH_STOP;
                            end else if (item.flag_txe) begin
                                res.byte_out_valid = 1'b1;
                                res.byte_out       = item.data_byte;
                                res.data_taken     = 1'b1;
                                bl                 = bl - LEN_BITS'(1);
                                if (bl == '0) begin
                                    s.phase = PH_STOP;
                                end
                            end
                        end
                        PH_RX: begin
                            if (bl == '0) begin
                                // Empty read: release the bus at once
                                res.send_stop = 1'b1;
                                s.phase       = PH_CLOSE;
                            end else if (item.flag_rxne) begin
                                res.clear_ack = (bl <= LEN_BITS'(2));
                                res.rx_valid  = 1'b1;
                                res.rx_byte   = item.data_byte;
                                bl            = bl - LEN_BITS'(1);
                                if (bl == '0) begin
                                    s.phase = PH_STOP;
                                end
                            end
                        end
                        PH_STOP: begin
                            if (item.flag_btf) begin
                                res.send_stop = 1'b1;
                                s.phase       = PH_CLOSE;
                            end
                        end
                        PH_CLOSE: begin
                            if (!item.bus_busy) begin
                                s.active     = 1'b0;
                                s.phase      = PH_IDLE;
                                res.done_res = 1'b1;
                            end
                        end
                        default: begin
                            s.phase = s.phase;
                        end
                    endcase
                end
            end
        end

        res.start_error = err;
        res.is_busy     = s.active;
        st_next         = s;
        bytes_left_next = bl;
        extra_word_next = xw;
    end

endmodule
`default_nettype wire
